@@ rtl/core/rmts_pkg.sv @@
// Shared constants, types and helpers for the rate-monotonic task scheduler.
package rmts_pkg;

  // Table depth and time counter width
  localparam int MAX_TASKS  = 16;
  localparam int TIME_WIDTH = 32;

  // Derived widths
  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CFG_W  = 5;
  localparam int CMP_W  = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
  localparam int FLD_W  = 16;
  localparam int SLOT_W = 4;

  // Item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             live;
    logic             run;
    logic             best_v;
    logic [FLD_W-1:0] best_per;
    logic [IDX_W-1:0] best_idx;
    logic             and_rest;
  } tok_t;

  // Update broadcast from the sequencer to every cell
  typedef struct packed {
    logic             ld_we;
    logic [IDX_W-1:0] ld_slot;
    logic [FLD_W-1:0] ld_per;
    logic [FLD_W-1:0] ld_exec;
    logic [FLD_W-1:0] ld_jobs;
    logic             commit;
    logic [IDX_W-1:0] win_idx;
  } upd_t;

  // Per-cell status seen by the sequencer for the winning task
  typedef struct packed {
    logic                  finish;
    logic                  done_after;
    logic [TIME_WIDTH-1:0] nxt;
    logic [TIME_WIDTH-1:0] used;
  } stat_t;

  // Saturating add of a time value and an increment
  function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                    input logic [TIME_WIDTH-1:0] b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
  endfunction

endpackage

@@ rtl/core/rmts_cell.sv @@
// One task slot of the scheduler chain: task table entry, progress state and a search stage.
module rmts_cell import rmts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IDX_W-1:0]      cell_idx,
  input  logic                  active,
  input  logic [TIME_WIDTH-1:0] now,
  input  tok_t                  tok_in,
  output tok_t                  tok_out,
  input  upd_t                  upd,
  output stat_t                 stat
);

  logic [FLD_W-1:0]      per_r, exec_r, jobs_r;
  logic [FLD_W-1:0]      done_r, done_nxt;
  logic [FLD_W-1:0]      units_r, units_nxt;
  logic [TIME_WIDTH-1:0] rel_r, rel_nxt;
  tok_t                  tok_r, tok_nxt;

  logic [FLD_W-1:0] units_inc, done_inc;
  logic             is_done, elig, take;

  assign units_inc = units_r + FLD_W'(1);
  assign done_inc  = done_r + FLD_W'(1);
  assign is_done   = (done_r >= jobs_r);
  assign elig      = tok_in.run && active && !is_done && (rel_r <= now);
  assign take      = elig && (!tok_in.best_v || (per_r < tok_in.best_per));

  // status for the commit step when this cell wins
  always_comb begin
    stat.finish     = (units_inc >= exec_r);
    stat.done_after = (done_inc >= jobs_r);
    stat.nxt        = sat_add(rel_r, TIME_WIDTH'(per_r));
    stat.used       = sat_add(rel_r, TIME_WIDTH'(exec_r));
  end

  // search stage: compare against the best so far, fold done flags
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.live && active) begin
      if (take) begin
        tok_nxt.best_v   = 1'b1;
        tok_nxt.best_per = per_r;
        tok_nxt.best_idx = cell_idx;
        tok_nxt.and_rest = tok_in.and_rest && !tok_in.best_v;
      end else if (elig) begin
        tok_nxt.and_rest = 1'b0;
      end else begin
        tok_nxt.and_rest = tok_in.and_rest && is_done;
      end
    end
  end

  // progress state: load restarts, commit runs one unit
  always_comb begin
    done_nxt  = done_r;
    units_nxt = units_r;
    rel_nxt   = rel_r;
    if (upd.ld_we && (upd.ld_slot == cell_idx)) begin
      done_nxt  = '0;
      units_nxt = '0;
      rel_nxt   = '0;
    end else if (upd.commit && (upd.win_idx == cell_idx)) begin
      if (stat.finish) begin
        units_nxt = '0;
        done_nxt  = done_inc;
        rel_nxt   = stat.nxt;
      end else begin
        units_nxt = units_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      units_r <= '0;
      rel_r   <= '0;
      tok_r   <= '0;
    end else begin
      done_r  <= done_nxt;
      units_r <= units_nxt;
      rel_r   <= rel_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // task table entry
  always_ff @(posedge clk) begin
    if (upd.ld_we && (upd.ld_slot == cell_idx)) begin
      per_r  <= upd.ld_per;
      exec_r <= upd.ld_exec;
      jobs_r <= upd.ld_jobs;
    end
  end

  assign tok_out = tok_r;

endmodule

@@ rtl/core/rate_monotonic_task_scheduler.sv @@
// Top level of the rate-monotonic task scheduler: sequencer, cell chain and result register.
//
// Usage: the input channel (in_valid / in_stall) takes one word per item. Opcode load
// writes a task slot (period, exec_time, job_count) and restarts that task; opcode tick
// advances time one unit, running the released unfinished task with the shortest
// period (lowest index on ties). Every item produces exactly one result word on the
// output channel (out_valid / out_stall).
// cfg_data sets task_count through a valid/ready write port that is always ready;
// write it only while the block is idle.
// An item passes through a write step (loads only), a start step, the search token walking
// the chain of MAX_TASKS cells one cell per cycle, and a commit step. One item is in work
// at a time, so a new item is accepted only after the last one has committed.
// The result register lets the next item be accepted while a result waits; if the
// receiver stalls, the following item completes its search and then holds until the
// result register frees up. in_stall is high while an item is in work.
// Reset (synchronous, rst_n low) clears progress, time and miss counters, sets
// task_count to 1; the task table itself is undefined until loaded.
module rate_monotonic_task_scheduler import rmts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [SLOT_W-1:0]     in_task_index,
  input  logic [FLD_W-1:0]      in_period,
  input  logic [FLD_W-1:0]      in_exec_time,
  input  logic [FLD_W-1:0]      in_job_count,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_current_time,
  output logic                  out_running_valid,
  output logic [3:0]            out_running_task,
  output logic                  out_job_finished,
  output logic                  out_deadline_missed,
  output logic [31:0]           out_job_wait,
  output logic [31:0]           out_miss_total,
  output logic                  out_all_done,
  // configuration port
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  state_t state_r, state_nxt;

  // captured item word
  logic             op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [FLD_W-1:0] per_r, exec_r, jobs_r;

  logic [CFG_W-1:0]      task_count_r;
  logic [TIME_WIDTH-1:0] tick_r, tick_nxt;
  logic [31:0]           miss_r, miss_nxt;
  tok_t                  final_r;

  tok_t             tok_w [0:MAX_TASKS];
  stat_t            stat_w [0:MAX_TASKS-1];
  logic [MAX_TASKS-1:0] active;
  upd_t             upd;

  logic accept, start, ld_go, commit_go;

  // result values built in the commit step
  stat_t                 win_st;
  logic [TIME_WIDTH-1:0] fin;
  logic                  res_run, res_fin, res_miss, res_all;
  logic [TIME_WIDTH-1:0] res_wait;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = (in_opcode == OP_LOAD) ? ST_LOAD : ST_START;
      ST_LOAD:   state_nxt = ST_START;
      ST_START:  state_nxt = ST_SCAN;
      ST_SCAN:   if (tok_w[MAX_TASKS].live) state_nxt = ST_COMMIT;
      ST_COMMIT: if (!out_valid || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    ld_go     = 1'b0;
    start     = 1'b0;
    commit_go = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall  = 1'b0;
      ST_LOAD:   ld_go     = 1'b1;
      ST_START:  start     = 1'b1;
      ST_SCAN:   ;
      ST_COMMIT: commit_go = !out_valid || !out_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      slot_r <= in_task_index;
      per_r  <= in_period;
      exec_r <= in_exec_time;
      jobs_r <= in_job_count;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      task_count_r <= cfg_data;
    end
  end

  // cell chain
  always_comb begin
    tok_w[0]          = '0;
    tok_w[0].live     = start;
    tok_w[0].run      = (op_r == OP_TICK);
    tok_w[0].and_rest = 1'b1;
  end

  always_comb begin
    upd         = '0;
    upd.ld_we   = ld_go && (CMP_W'(slot_r) < CMP_W'(MAX_TASKS));
    upd.ld_slot = IDX_W'(slot_r);
    upd.ld_per  = per_r;
    upd.ld_exec = exec_r;
    upd.ld_jobs = jobs_r;
    upd.commit  = commit_go && final_r.best_v;
    upd.win_idx = final_r.best_idx;
  end

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    assign active[i] = CMP_W'(i) < CMP_W'(task_count_r);

    rmts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .active   (active[i]),
      .now      (tick_r),
      .tok_in   (tok_w[i]),
      .tok_out  (tok_w[i+1]),
      .upd      (upd),
      .stat     (stat_w[i])
    );
  end

  // token at the end of the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      final_r <= '0;
    end else if (state_r == ST_SCAN && tok_w[MAX_TASKS].live) begin
      final_r <= tok_w[MAX_TASKS];
    end
  end

  // commit step: finish check, deadline, waiting time, counters
  always_comb begin
    win_st   = stat_w[final_r.best_idx];
    fin      = sat_add(tick_r, TIME_WIDTH'(1));
    res_run  = final_r.best_v;
    res_fin  = res_run && win_st.finish;
    res_miss = res_fin && (fin > win_st.nxt);
    res_wait = (res_fin && (fin > win_st.used)) ? fin - win_st.used : '0;
    res_all  = res_run ? (final_r.and_rest && res_fin && win_st.done_after)
                       : final_r.and_rest;
    tick_nxt = (final_r.run) ? fin : tick_r;
    miss_nxt = (res_miss && (miss_r != 32'hFFFF_FFFF)) ? miss_r + 32'd1 : miss_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      miss_r <= '0;
    end else if (commit_go) begin
      tick_r <= tick_nxt;
      miss_r <= miss_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (commit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_current_time    <= 32'(tick_r);
      out_running_valid   <= res_run;
      out_running_task    <= res_run ? 4'(final_r.best_idx) : 4'd0;
      out_job_finished    <= res_fin;
      out_deadline_missed <= res_miss;
      out_job_wait        <= 32'(res_wait);
      out_miss_total      <= miss_nxt;
      out_all_done        <= res_all;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("item accepted while idle left the input open");

  a_miss_has_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deadline_missed |-> out_job_finished && out_running_valid)
    else $error("deadline miss reported without a finished job");

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[MAX_TASKS].live |-> state_r == ST_SCAN)
    else $error("search token left the chain outside the scan");

  a_miss_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> miss_r >= $past(miss_r))
    else $error("miss counter went down");

endmodule
